>>> hw/rtl/sobel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel package
// Shared types and constants for the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned POS_W = 11;
    localparam int unsigned DIM_W = 12;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    // Window for one interior pixel, p[row*3+col], row 0 oldest
    typedef struct packed {
        logic [8:0][PIX_W-1:0] p;
        logic [POS_W-1:0]      col;
        logic [POS_W-1:0]      row;
        logic                  last;
    } sobel_job_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } sobel_res_t;

    // Back end sequence: take job, gradients, squared sum, root steps, output
    typedef enum logic [2:0] {B_IDLE, B_GRAD, B_SUM, B_SQRT, B_OUT} back_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/sobel_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/sobel_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel front end
// Accept pixels, keep line stores and window, hand interior windows to queue.
// ----------------------------------------------------------------------------
module sobel_front #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire [sobel_pkg::PIX_W-1:0] in_pixel,
    input  wire [sobel_pkg::DIM_W-1:0] width_cfg,
    input  wire [sobel_pkg::DIM_W-1:0] height_cfg,
    output logic                      job_valid,
    input  wire                       job_ready,
    output sobel_pkg::sobel_job_t     job
);
    import sobel_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_WIDTH);
    localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned LIM = (DIM_W > CW ? DIM_W : CW) > RW ?
                                  (DIM_W > CW ? DIM_W : CW) : RW;

    // Two-phase: phase 0 accepts and reads RAMs, phase 1 shifts window
    logic              ph_reg, ph_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [PIX_W-1:0]  px_reg;
    logic [8:0][PIX_W-1:0] win_reg, win_next;
    logic [LIM-1:0]    w_eff, h_eff;
    logic [AW-1:0]     ci;
    logic [PIX_W-1:0]  up1, up2;
    logic              fire;
    logic              emit;
    logic              adv;

    always_comb begin
        w_eff = LIM'(width_cfg);
        if (width_cfg < DIM_W'(3)) w_eff = LIM'(3);
        else if (LIM'(width_cfg) > LIM'(MAX_WIDTH)) w_eff = LIM'(MAX_WIDTH);
        h_eff = LIM'(height_cfg);
        if (height_cfg < DIM_W'(3)) h_eff = LIM'(3);
        else if (LIM'(height_cfg) > LIM'(MAX_HEIGHT)) h_eff = LIM'(MAX_HEIGHT);
    end

    assign ci = (LIM'(col_reg) < LIM'(MAX_WIDTH)) ? col_reg[AW-1:0] : AW'(MAX_WIDTH - 1);
    assign in_ready = !ph_reg;
    assign fire = in_valid && in_ready;
    assign adv  = ph_reg && (!job_valid || job_ready);

    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .aclk(aclk), .we(adv), .waddr(ci),
        .wdata(px_reg), .re(fire), .raddr(ci), .rdata(up1));
    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .aclk(aclk), .we(adv), .waddr(ci),
        .wdata(up1), .re(fire), .raddr(ci), .rdata(up2));

    assign emit = (LIM'(row_reg) >= LIM'(2)) && (LIM'(col_reg) >= LIM'(2)) &&
                  (LIM'(row_reg) < h_eff) && (LIM'(col_reg) < w_eff);

    always_comb begin
        ph_next  = ph_reg;
        col_next = col_reg;
        row_next = row_reg;
        win_next = win_reg;
        if (fire) ph_next = 1'b1;
        if (adv) begin
            ph_next = 1'b0;
            for (int k = 0; k < 3; k++) begin
                win_next[k*3]   = win_reg[k*3+1];
                win_next[k*3+1] = win_reg[k*3+2];
            end
            win_next[2] = up2;
            win_next[5] = up1;
            win_next[8] = px_reg;
            if (LIM'(col_reg) + LIM'(1) >= w_eff) begin
                col_next = '0;
                row_next = (LIM'(row_reg) + LIM'(1) >= h_eff) ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg    <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
            win_reg   <= '0;
            job_valid <= 1'b0;
        end else begin
            ph_reg    <= ph_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            win_reg   <= win_next;
            job_valid <= (adv && emit) || (job_valid && !job_ready);
        end
        if (fire) px_reg <= in_pixel;
        if (adv && emit) begin
            job.p    <= win_next;
            job.col  <= POS_W'(col_reg - CW'(1));
            job.row  <= POS_W'(row_reg - RW'(1));
            job.last <= (LIM'(row_reg) == h_eff - LIM'(1)) &&
                        (LIM'(col_reg) == w_eff - LIM'(1));
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_in_phase1: assert property (@(posedge aclk) disable iff (!aresetn)
        ph_reg |-> !in_ready) else $error("pixel accepted mid-step");
    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && !job_ready |=> job_valid && $stable(job))
        else $error("job dropped");
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        LIM'(col_reg) <= LIM'(MAX_WIDTH)) else $error("column out of range");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/sobel_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel back end
// Gradients, squared sum, digit-by-digit integer square root, output register.
// ----------------------------------------------------------------------------
module sobel_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   job_valid,
    output logic                  job_ready,
    input  sobel_pkg::sobel_job_t job,
    output logic                  res_valid,
    input  wire                   res_ready,
    output sobel_pkg::sobel_res_t res
);
    import sobel_pkg::*;

    localparam logic [16:0] ROOT_TOP = 17'h04000;
    localparam logic [20:0] SAT_LIM  = 21'd65025;

    back_state_t        st_reg, st_next;
    sobel_job_t         j_reg;
    logic signed [11:0] gx_reg, gy_reg;
    logic signed [11:0] gx, gy;
    logic signed [23:0] gx_sq, gy_sq;
    logic [20:0]        sum;
    logic [16:0]        n_reg, r_reg, bit_reg;
    logic [16:0]        trial;
    logic               sat_reg;
    logic               out_go;

    function automatic logic signed [11:0] ext(input logic [7:0] v);
        return $signed({4'b0, v});
    endfunction

    always_comb begin
        gx = (ext(j_reg.p[2]) + (ext(j_reg.p[5]) <<< 1) + ext(j_reg.p[8]))
           - (ext(j_reg.p[0]) + (ext(j_reg.p[3]) <<< 1) + ext(j_reg.p[6]));
        gy = (ext(j_reg.p[0]) + (ext(j_reg.p[1]) <<< 1) + ext(j_reg.p[2]))
           - (ext(j_reg.p[6]) + (ext(j_reg.p[7]) <<< 1) + ext(j_reg.p[8]));
    end

    // Squares are non-negative and below 2^20, so their sum fits 21 bits
    assign gx_sq  = gx_reg * gx_reg;
    assign gy_sq  = gy_reg * gy_reg;
    assign sum    = gx_sq[20:0] + gy_sq[20:0];
    assign trial  = r_reg + bit_reg;
    assign out_go = !res_valid || res_ready;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            B_IDLE: if (job_valid) st_next = B_GRAD;
            B_GRAD: st_next = B_SUM;
            B_SUM:  st_next = B_SQRT;
            B_SQRT: if (bit_reg == 17'd1) st_next = B_OUT;
            B_OUT:  if (out_go) st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    always_comb begin
        job_ready = (st_reg == B_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= B_IDLE;
            res_valid <= 1'b0;
        end else begin
            st_reg    <= st_next;
            res_valid <= (st_reg == B_OUT && out_go) || (res_valid && !res_ready);
        end
        unique case (st_reg)
            B_IDLE: if (job_valid) j_reg <= job;
            B_GRAD: begin
                gx_reg <= gx;
                gy_reg <= gy;
            end
            B_SUM: begin
                sat_reg <= sum >= SAT_LIM;
                n_reg   <= sum[16:0];
                r_reg   <= '0;
                bit_reg <= ROOT_TOP;
            end
            // One root bit per cycle, down to the unit bit
            B_SQRT: begin
                if (n_reg >= trial) begin
                    n_reg <= n_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            B_OUT: begin
                if (out_go) begin
                    res.edge_value <= sat_reg ? 8'd255 : r_reg[7:0];
                    res.col  <= j_reg.col;
                    res.row  <= j_reg.row;
                    res.last <= j_reg.last;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_res_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |-> st_reg == B_IDLE) else $error("job taken while busy");
    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == B_OUT |-> sat_reg || r_reg <= 17'd255)
        else $error("root above 255 without saturation");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/sobel_edge_magnitude.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel edge detector with gradient magnitude output.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// s_axis  | in  | pixel word
// m_axis  | out | edge value, column, row; tlast ends the frame
// cfg     | in  | register index 0 width, 1 height
//
// The front end reads the line stores at the accepting edge of a pixel word,
// then shifts the window and writes back; that second step waits while an
// earlier job is still held. The back end takes each interior result through
// take, gradients, squared sum, eight root steps and output, and takes its next
// job only once back in its idle state. Reset is synchronous; the line
// stores need no clearing. A stalled result holds the back end; once the
// one-entry queue fills, the front end holds its pixel and drops s_axis_tready.
module sobel_edge_magnitude #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // [7:0] pixel
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] edge_value, [18:8] out_col, [29:19] out_row
    output logic        m_axis_tlast,   // frame_last
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [0:0]   cfg_index,
    input  wire [11:0]  cfg_data
);
    import sobel_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    sobel_job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;
    sobel_res_t res;

    assign cfg_ready = 1'b1;
    // Hold the two dimension registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sobel_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .in_pixel(s_axis_tdata), .width_cfg(width_reg),
        .height_cfg(height_reg), .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

    // One-entry queue between front and back
    logic qv_reg;
    assign f_ready = !qv_reg || q_ready;
    assign q_valid = qv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) qv_reg <= 1'b0;
        else if (f_ready) qv_reg <= f_valid;
        if (f_ready && f_valid) q_job <= f_job;
    end

    sobel_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(q_valid), .job_ready(q_ready),
        .job(q_job), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res));

    assign m_axis_tdata = {2'b0, res.row, res.col, res.edge_value};
    assign m_axis_tlast = res.last;
endmodule
`default_nettype wire
